>>> hw/rtl/prrt_pkg.sv
// ----------------------------------------------------------------------------
// prrt_pkg
// Shared types and constants for the pending request ring with timeout.
// ----------------------------------------------------------------------------
package prrt_pkg;

    localparam int unsigned RING_DEPTH_DEF = 256;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd5;

    // Function codes of a request transaction
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] now_seconds;
        logic [31:0] ip_address;
        logic [15:0] port;
        logic [63:0] ping_id;
        logic [63:0] new_id;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [63:0] assigned_id;
        logic [8:0]  pending_count;
    } t_rsp;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
        logic [63:0] id;
        logic [31:0] stamp;
    } t_entry;

endpackage

>>> hw/rtl/pending_request_ring_with_timeout.sv
// ----------------------------------------------------------------------------
// pending_request_ring_with_timeout
// Ring of outstanding requests in send order, with expiry and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req and pulse start while busy is low; the
//   transaction is taken at that clock edge. func selects add or query.
//   Result channel: o_done is high for exactly one cycle with o_rsp; the
//   receiver must take it then, it cannot stall the block.
//   Configuration: i_cfg_we writes i_cfg_wdata into the timeout register;
//   write only while no transaction is in progress.
// Sequencing (one transaction at a time, all from one entry RAM with a
// single read port and a registered read):
//   - query with address 0 and id 0: result in the cycle after accept.
//   - otherwise an expiry walk first drops expired entries from the head,
//     then add writes the new entry; query scans live entries until a hit.
// Reset: synchronous, head and count go to zero, timeout goes to 5. The
// entry RAM is not cleared; only live entries are ever read.
// ----------------------------------------------------------------------------
module pending_request_ring_with_timeout #(
    parameter int unsigned RING_DEPTH = prrt_pkg::RING_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  prrt_pkg::t_req  i_req,
    output logic            o_done,
    output prrt_pkg::t_rsp  o_rsp,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_wdata
);

    localparam int IW = $clog2(RING_DEPTH);      // slot index width
    localparam int CW = $clog2(RING_DEPTH + 1);  // live count width
    localparam logic [IW-1:0] LAST_SLOT = IW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(RING_DEPTH);

    // Sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXP_RD  = 3'd1;
    localparam logic [2:0] ST_EXP_CHK = 3'd2;
    localparam logic [2:0] ST_ADD     = 3'd3;
    localparam logic [2:0] ST_MATCH   = 3'd4;

    // Entry storage: one synchronous RAM, one write and one read port
    prrt_pkg::t_entry r_mem [RING_DEPTH];
    prrt_pkg::t_entry r_rdata;

    logic [2:0]     r_state, n_state;
    logic [IW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [IW-1:0]  r_ptr, n_ptr;     // next slot to read during the scan
    logic [CW-1:0]  r_left, n_left;   // reads still to issue in the scan
    logic           r_rvld, n_rvld;   // r_rdata holds a scan entry
    logic [15:0]    r_timeout;
    prrt_pkg::t_req r_req;
    logic           r_done, n_done;
    prrt_pkg::t_rsp r_rsp, n_rsp;

    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    prrt_pkg::t_entry wr_data;

    logic             accept;
    logic             empty_query;
    logic             expired;
    logic             hit;
    logic             full;
    logic [IW:0]      slot_sum;
    logic [IW-1:0]    tail_slot;

    function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    assign accept      = start && !busy;
    assign empty_query = (i_req.func == prrt_pkg::FUNC_QUERY) &&
                         (i_req.ip_address == '0) && (i_req.ping_id == '0);

    // Expired when stamp + timeout < now, formed at 33 bits so it never wraps
    assign expired = ({1'b0, r_rdata.stamp} + 33'(r_timeout)) < {1'b0, r_req.now_seconds};

    // Address 0 matches any address and port, id 0 matches any id
    assign hit = ((r_req.ip_address == '0) ||
                  (r_rdata.address == r_req.ip_address && r_rdata.port == r_req.port)) &&
                 ((r_req.ping_id == '0) || (r_rdata.id == r_req.ping_id));

    // Tail slot: head + count, wrapped once (count <= DEPTH-1 when not full)
    assign full      = (r_count == FULL_CNT);
    assign slot_sum  = {1'b0, r_head} + (IW + 1)'(r_count);
    assign tail_slot = (slot_sum >= (IW + 1)'(RING_DEPTH)) ?
                       IW'(slot_sum - (IW + 1)'(RING_DEPTH)) : IW'(slot_sum);

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_left  = r_left;
        n_rvld  = 1'b0;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        rd_en   = 1'b0;
        rd_addr = r_head;
        wr_en   = 1'b0;
        wr_addr = tail_slot;
        wr_data = '{address: r_req.ip_address, port: r_req.port,
                    id: r_req.new_id, stamp: r_req.now_seconds};

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (empty_query) begin
                        // Answer at once, touch nothing
                        n_done = 1'b1;
                        n_rsp  = '{found: 1'b0, assigned_id: '0,
                                   pending_count: 9'(r_count)};
                    end else begin
                        n_state = ST_EXP_RD;
                    end
                end
            end
            ST_EXP_RD: begin
                if (r_count == '0) begin
                    n_ptr   = r_head;
                    n_left  = '0;
                    n_state = (r_req.func == prrt_pkg::FUNC_ADD) ? ST_ADD : ST_MATCH;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_state = ST_EXP_CHK;
                end
            end
            ST_EXP_CHK: begin
                if (expired) begin
                    // Drop the oldest entry and look at the next one
                    n_head  = slot_inc(r_head);
                    n_count = r_count - 1'b1;
                    n_state = ST_EXP_RD;
                end else begin
                    n_ptr   = r_head;
                    n_left  = r_count;
                    n_state = (r_req.func == prrt_pkg::FUNC_ADD) ? ST_ADD : ST_MATCH;
                end
            end
            ST_ADD: begin
                wr_en = 1'b1;
                if (full) begin
                    // Overwrite the oldest slot, the ring stays full
                    wr_addr = r_head;
                    n_head  = slot_inc(r_head);
                end else begin
                    n_count = r_count + 1'b1;
                end
                n_done  = 1'b1;
                n_rsp   = '{found: 1'b0, assigned_id: r_req.new_id,
                            pending_count: 9'(n_count)};
                n_state = ST_IDLE;
            end
            ST_MATCH: begin
                if (r_rvld && hit) begin
                    n_done  = 1'b1;
                    n_rsp   = '{found: 1'b1, assigned_id: '0,
                                pending_count: 9'(r_count)};
                    n_state = ST_IDLE;
                end else if (r_left == '0) begin
                    n_done  = 1'b1;
                    n_rsp   = '{found: 1'b0, assigned_id: '0,
                                pending_count: 9'(r_count)};
                    n_state = ST_IDLE;
                end else begin
                    // Issue the next read, check it next cycle
                    rd_en   = 1'b1;
                    rd_addr = r_ptr;
                    n_ptr   = slot_inc(r_ptr);
                    n_left  = r_left - 1'b1;
                    n_rvld  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_ptr     <= '0;
            r_left    <= '0;
            r_rvld    <= 1'b0;
            r_done    <= 1'b0;
            r_timeout <= prrt_pkg::TIMEOUT_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_left  <= n_left;
            r_rvld  <= n_rvld;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (accept) begin
            r_req <= i_req;
        end
    end

    // Entry RAM
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/prrt_chk.sv
// ----------------------------------------------------------------------------
// prrt_chk
// Port-level checks for the pending request ring, bound to the top level.
// ----------------------------------------------------------------------------
module prrt_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input prrt_pkg::t_req i_req,
    input logic           o_done,
    input prrt_pkg::t_rsp o_rsp
);

    // An accepted transaction either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted transaction neither answered nor busy");

    // An add always walks the ring, so it never answers at once
    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.func == prrt_pkg::FUNC_ADD) |=> busy)
        else $error("add did not enter the ring walk");

    // Leaving the busy phase always hands out a result
    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // A found result comes from a query, which reports no assigned id
    a_found_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.found) |-> (o_rsp.assigned_id == '0))
        else $error("found result carries an assigned id");

endmodule

bind pending_request_ring_with_timeout prrt_chk u_prrt_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
